/* design/plc_pkg.sv */
// ============================================================================
// plc_pkg
// Shared types, codes and widths for the positional list engine.
// ============================================================================
package plc_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int ELEMENT_BITS_DEF = 32;

    localparam int CMD_BITS    = 3;
    localparam int POS_BITS    = 16;
    localparam int ELEM_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam logic [CMD_BITS-1:0] CMD_APPEND    = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT_AT = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_REM_LAST  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_REM_AT    = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_READ_AT   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_READ_LAST = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOPOS = 2'd3;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } plc_op_t;

endpackage

/* design/plc_cell.sv */
// ============================================================================
// plc_cell
// One list slot. Loads a new item, its left or right neighbor, or holds,
// by comparing its own index with the broadcast position and count.
// ============================================================================
module plc_cell #(
    parameter int INDEX        = 0,
    parameter int ELEMENT_BITS = plc_pkg::ELEMENT_BITS_DEF,
    parameter int CNT_BITS     = 5
) (
    input  logic                    clk,
    input  plc_pkg::plc_op_t        op,
    input  logic [CNT_BITS-1:0]     pos,
    input  logic [CNT_BITS-1:0]     cnt,
    input  logic [ELEMENT_BITS-1:0] value,
    input  logic [ELEMENT_BITS-1:0] left,
    input  logic [ELEMENT_BITS-1:0] right,
    output logic [ELEMENT_BITS-1:0] q
);
    import plc_pkg::*;

    localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(INDEX);

    logic [ELEMENT_BITS-1:0] data_reg;
    logic [ELEMENT_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            if (IDX == pos)
                data_next = value;
            else if (IDX > pos && IDX <= cnt)
                data_next = left;
        end
        else if (op.rem)
        begin
            if (IDX >= pos && (IDX + 1'b1) < cnt)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

/* design/positional_list_engine_core.sv */
// ============================================================================
// positional_list_engine_core
// Bounded ordered list of element handles built as a row of shifting cells.
// ============================================================================
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while in_stall is low; every cell shifts in parallel under a
// compare of its index with the position, so no command iterates.
// Reset: count and output valid clear; cell contents are undefined until
// written and are never read beyond the count.
module positional_list_engine_core #(
    parameter int CAPACITY     = plc_pkg::CAPACITY_DEF,
    parameter int ELEMENT_BITS = plc_pkg::ELEMENT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [plc_pkg::CMD_BITS-1:0]    command,
    input  logic [plc_pkg::POS_BITS-1:0]    position,
    input  logic [plc_pkg::ELEM_BITS-1:0]   element,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [plc_pkg::STATUS_BITS-1:0] status,
    output logic [plc_pkg::ELEM_BITS-1:0]   element_out,
    output logic [plc_pkg::COUNT_BITS-1:0]  count
);
    import plc_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

    logic [CNT_BITS-1:0]     cnt_reg;
    logic [CNT_BITS-1:0]     cnt_next;
    logic                    out_valid_reg;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [ELEM_BITS-1:0]    elem_reg;
    logic [COUNT_BITS-1:0]   count_reg;

    logic                    in_acc;
    logic                    full;
    logic                    empty;
    logic [POS_BITS-1:0]     cnt_w;
    logic [POS_BITS-1:0]     last_w;
    logic [CNT_BITS-1:0]     last_c;
    logic                    do_ins;
    logic                    do_rem;
    logic                    do_rd;
    logic [CNT_BITS-1:0]     op_pos;
    logic [IDX_BITS-1:0]     rd_idx;
    logic [ELEMENT_BITS-1:0] rd_val;
    logic [STATUS_BITS-1:0]  st;
    logic [ELEMENT_BITS-1:0] value_w;
    plc_op_t                 op;

    logic [ELEMENT_BITS-1:0] cell_q [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    assign full    = (cnt_reg == CAP_CNT);
    assign empty   = (cnt_reg == '0);
    assign cnt_w   = POS_BITS'(cnt_reg);
    assign last_c  = cnt_reg - 1'b1;
    assign last_w  = POS_BITS'(last_c);
    assign value_w = ELEMENT_BITS'(element);

    always_comb
    begin
        do_ins = 1'b0;
        do_rem = 1'b0;
        do_rd  = 1'b0;
        op_pos = cnt_reg;
        rd_idx = IDX_BITS'(position);
        st     = ST_OK;
        case (command)
            CMD_APPEND:
            begin
                if (full)
                    st = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            CMD_INSERT_AT:
            begin
                if (full)
                    st = ST_FULL;
                else
                    do_ins = 1'b1;
                if (position < cnt_w)
                    op_pos = CNT_BITS'(position);
            end
            CMD_REM_LAST:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                    do_rem = 1'b1;
                op_pos = last_c;
            end
            CMD_REM_AT:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                    do_rem = 1'b1;
                if (position >= last_w)
                    op_pos = last_c;
                else
                    op_pos = CNT_BITS'(position);
            end
            CMD_READ_AT:
            begin
                if (empty)
                    st = ST_EMPTY;
                else if (position >= cnt_w)
                    st = ST_NOPOS;
                else
                    do_rd = 1'b1;
            end
            CMD_READ_LAST:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                    do_rd = 1'b1;
                rd_idx = IDX_BITS'(last_c);
            end
            default:
            begin
                st = ST_NOPOS;
            end
        endcase
    end

    assign op.ins = do_ins && in_acc;
    assign op.rem = do_rem && in_acc;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_ins)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rem)
            cnt_next = cnt_reg - 1'b1;
    end

    always_comb
    begin
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rd_idx == IDX_BITS'(i))
                rd_val = rd_val | cell_q[i];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ELEMENT_BITS-1:0] left_w;
        logic [ELEMENT_BITS-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[g+1];
        end

        plc_cell #(
            .INDEX        (g),
            .ELEMENT_BITS (ELEMENT_BITS),
            .CNT_BITS     (CNT_BITS)
        ) u_cell (
            .clk   (clk),
            .op    (op),
            .pos   (op_pos),
            .cnt   (cnt_reg),
            .value (value_w),
            .left  (left_w),
            .right (right_w),
            .q     (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg <= st;
            elem_reg   <= do_rd ? ELEM_BITS'(rd_val) : '0;
            count_reg  <= COUNT_BITS'(cnt_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign element_out = elem_reg;
    assign count       = count_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("count beyond capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && command == CMD_APPEND && !full |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("append did not grow the list");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == COUNT_BITS'(CAPACITY))
        else $error("full status with list not full");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> element_out == '0)
        else $error("error result carries an element");
`endif

endmodule

/* test/positional_list_engine_core_test.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_core_test
// Drives list commands through the valid/stall input channel with random
// gaps and output back-pressure. A mirror of the list predicts status,
// element and count for every accepted item, and each result that comes out
// is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module positional_list_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;
    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [ELEM_BITS-1:0]   element;
        logic [COUNT_BITS-1:0]  count;
    } list_result_t;

    class list_mirror;
        logic [ELEM_BITS-1:0] cells [LIST_CAP];
        int unsigned          held;
        list_result_t         expected_results [$];
        int                   failures;

        function new();
            held     = 0;
            failures = 0;
        endfunction

        function logic [STATUS_BITS-1:0] insert_at(int unsigned pos, logic [ELEM_BITS-1:0] el);
            int unsigned p;
            if (held >= LIST_CAP)
                return ST_FULL;
            p = (pos > held) ? held : pos;
            for (int unsigned i = held; i > p; i--)
                cells[i] = cells[i-1];
            cells[p] = el;
            held++;
            return ST_OK;
        endfunction

        function logic [STATUS_BITS-1:0] remove_at(int unsigned pos);
            int unsigned p;
            if (held == 0)
                return ST_EMPTY;
            p = (pos >= held - 1) ? held - 1 : pos;
            for (int unsigned i = p; i + 1 < held; i++)
                cells[i] = cells[i+1];
            held--;
            return ST_OK;
        endfunction

        function void apply_command(logic [CMD_BITS-1:0] cmd, logic [POS_BITS-1:0] pos,
                                    logic [ELEM_BITS-1:0] el);
            list_result_t r;
            r.status  = ST_OK;
            r.element = '0;
            case (cmd)
                CMD_APPEND:    r.status = insert_at(held, el);
                CMD_INSERT_AT: r.status = insert_at(pos, el);
                CMD_REM_LAST:  r.status = remove_at(held);
                CMD_REM_AT:    r.status = remove_at(pos);
                CMD_READ_AT:
                begin
                    if (held == 0)
                        r.status = ST_EMPTY;
                    else if (pos >= held)
                        r.status = ST_NOPOS;
                    else
                        r.element = cells[pos];
                end
                CMD_READ_LAST:
                begin
                    if (held == 0)
                        r.status = ST_EMPTY;
                    else
                        r.element = cells[held-1];
                end
                default:       r.status = ST_NOPOS;
            endcase
            r.count = held[COUNT_BITS-1:0];
            expected_results.push_back(r);
        endfunction

        function void compare_result(logic [STATUS_BITS-1:0] st, logic [ELEM_BITS-1:0] el,
                                     logic [COUNT_BITS-1:0] cnt);
            list_result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d element %h count %0d",
                         $time, st, el, cnt);
                failures++;
                return;
            end
            e = expected_results.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
                failures++;
            end
            if (el !== e.element)
            begin
                $display("%0t: element_out mismatch: expected %h, actual %h",
                         $time, e.element, el);
                failures++;
            end
            if (cnt !== e.count)
            begin
                $display("%0t: count mismatch: expected %0d, actual %0d", $time, e.count, cnt);
                failures++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CMD_BITS-1:0]    command = CMD_APPEND;
    logic [POS_BITS-1:0]    position = '0;
    logic [ELEM_BITS-1:0]   element = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_BITS-1:0] status;
    logic [ELEM_BITS-1:0]   element_out;
    logic [COUNT_BITS-1:0]  count;

    list_mirror mirror = new();
    bit         no_idle = 1'b0;
    int         cycle_count = 0;

    positional_list_engine_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .position    (position),
        .element     (element),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .element_out (element_out),
        .count       (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [POS_BITS-1:0] pos,
                             logic [ELEM_BITS-1:0] el);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        position <= pos;
        element  <= el;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        mirror.apply_command(cmd, pos, el);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stall before each item, then hold stall low until one is taken
    initial
    begin
        int hold;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            mirror.compare_result(status, element_out, count);
        end
    end

    initial
    begin
        int                   sent;
        int                   bias;
        int                   roll;
        logic [CMD_BITS-1:0]  cmd;
        logic [POS_BITS-1:0]  pos;
        logic [ELEM_BITS-1:0] el;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list
        send_item(CMD_READ_LAST, 16'd0, 32'h0);
        send_item(CMD_READ_AT, 16'd0, 32'h0);
        send_item(CMD_REM_LAST, 16'd0, 32'h0);
        send_item(CMD_REM_AT, 16'd0, 32'h0);
        // front, back and past-the-end inserts
        send_item(CMD_APPEND, 16'd0, 32'hFFFF_FFFF);
        send_item(CMD_INSERT_AT, 16'd0, 32'h0);
        send_item(CMD_INSERT_AT, 16'hFFFF, 32'hA5A5_5A5A);
        send_item(CMD_READ_AT, 16'd1, 32'h0);
        send_item(CMD_READ_AT, 16'd3, 32'h0);
        send_item(CMD_READ_AT, 16'hFFFF, 32'h0);
        send_item(CMD_READ_LAST, 16'hFFFF, 32'h0);
        send_item(CMD_REM_AT, 16'd0, 32'h0);
        send_item(CMD_REM_AT, 16'hFFFF, 32'h0);
        send_item(CMD_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_SPARE_7, 16'd5, 32'h1234_5678);
        // fill to capacity, then overflow
        while (mirror.held < LIST_CAP)
            send_item(CMD_INSERT_AT, 16'(mirror.held / 2), $urandom);
        send_item(CMD_INSERT_AT, 16'd3, 32'hDEAD_BEEF);
        send_item(CMD_APPEND, 16'd0, 32'hFFFF_FFFF);
        send_item(CMD_READ_AT, 16'(LIST_CAP - 1), 32'h0);

        drain_results();

        sent = 0;
        bias = 2;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 100 == 0)
            begin
                bias    = $urandom_range(0, 3);
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                    drain_results();
            end

            roll = $urandom_range(0, 9);
            if (roll == 0)
                pos = 16'($urandom);
            else if (roll == 1)
                pos = 16'hFFFF;
            else
                pos = 16'($urandom_range(0, mirror.held + 2));
            el = $urandom;

            if ($urandom_range(0, 39) == 0)
            begin
                send_item($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7, pos, el);
                continue;
            end

            roll = $urandom_range(0, 99);
            case (bias)
                0:       roll = (roll < 50) ? 0 : (roll < 70) ? 1 : 2;
                1:       roll = (roll < 20) ? 0 : (roll < 70) ? 1 : 2;
                2:       roll = (roll < 35) ? 0 : (roll < 65) ? 1 : 2;
                default: roll = (roll < 20) ? 0 : (roll < 35) ? 1 : 2;
            endcase
            case (roll)
                0:       cmd = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT_AT;
                1:       cmd = $urandom_range(0, 1) ? CMD_REM_LAST : CMD_REM_AT;
                default: cmd = ($urandom_range(0, 9) < 7) ? CMD_READ_AT : CMD_READ_LAST;
            endcase
            send_item(cmd, pos, el);
            sent++;
        end
        in_valid <= 1'b0;

        drain_results();
        repeat (5) @(posedge clk);

        if (mirror.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
